/* rtl/b2b_pkg.sv */
// ----------------------------------------------------------------------------
// b2b_pkg
// Shared constants and the beat type for the binary-to-BCD converter.
// ----------------------------------------------------------------------------
`default_nettype none

package b2b_pkg;

	// Digit stages in the pipeline and width of the binary operand
	localparam int MAX_DIGITS  = 8;
	localparam int VALUE_WIDTH = 32;

	// Port widths fixed by the interface
	localparam int IN_W   = 32;
	localparam int OUT_W  = 32;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int CFG_W  = 4;

	// Derived widths
	localparam int BCD_W = 4 * MAX_DIGITS;
	localparam int CNT_W = $clog2(MAX_DIGITS + 1);

	// Register map (word index taken from paddr[2])
	localparam logic REG_DIGITS = 1'b0;

	// Reset digit count
	localparam logic [CFG_W-1:0] DIGITS_RESET = CFG_W'(8);

	// Decimal radix and its scaled reciprocal: floor(2^(W+4) / 10)
	localparam logic [4:0] TEN = 5'd10;
	localparam logic [VALUE_WIDTH:0] RECIP_TEN =
		(VALUE_WIDTH + 1)'((64'd1 << (VALUE_WIDTH + 4)) / 64'd10);
	localparam int RECIP_SHIFT = VALUE_WIDTH + 4;

	// One item as it travels through the digit stages
	typedef struct packed {
		logic [VALUE_WIDTH-1:0] value;  // quotient still to be split
		logic [BCD_W-1:0]       bcd;    // digits so far, shifted in at the top
		logic [CNT_W-1:0]       left;   // digits still in use
		logic                   ovf;    // value did not fit the digits in use
	} b2b_beat_t;

endpackage

`default_nettype wire

/* rtl/b2b_digit.sv */
// ----------------------------------------------------------------------------
// b2b_digit
// One decimal digit: reciprocal multiply in the first stage, remainder
// correction and digit insert in the second. Each stage has its own valid
// bit, so bubbles are squeezed out while the downstream side is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module b2b_digit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire b2b_pkg::b2b_beat_t in_beat,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output b2b_pkg::b2b_beat_t      out_beat
);

	localparam int W = b2b_pkg::VALUE_WIDTH;

	logic                  valid_s1;
	logic                  valid_s2;
	logic                  adv_s1;
	logic                  adv_s2;
	logic [W-1:0]          q0_s1;
	b2b_pkg::b2b_beat_t    beat_s1;
	b2b_pkg::b2b_beat_t    beat_s2;
	logic [2*W:0]          product;
	logic [4:0]            q10_lo;
	logic [4:0]            rem_raw;
	logic                  fix;
	logic [W-1:0]          quot;
	logic [3:0]            digit;
	b2b_pkg::b2b_beat_t    next_beat;

	// Stage advances when empty or when its content moves on
	assign adv_s2   = !valid_s2 || out_ready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	// Estimate the quotient; it is exact or one short
	assign product = (2*W+1)'(in_beat.value) * (2*W+1)'(b2b_pkg::RECIP_TEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			q0_s1   <= W'(product >> b2b_pkg::RECIP_SHIFT);
			beat_s1 <= in_beat;
		end
	end

	// Remainder stays below twenty, so five low bits suffice
	always_comb begin
		q10_lo  = 5'(q0_s1 << 3) + 5'(q0_s1 << 1);
		rem_raw = beat_s1.value[4:0] - q10_lo;
		fix     = (rem_raw >= b2b_pkg::TEN);
		quot    = q0_s1 + W'(fix);
		digit   = fix ? 4'(rem_raw - b2b_pkg::TEN) : 4'(rem_raw);
	end

	// Shift the digit in at the top; digits past the count in use read zero
	always_comb begin
		next_beat       = beat_s1;
		next_beat.value = quot;
		if (beat_s1.left != '0) begin
			next_beat.bcd  = {digit, beat_s1.bcd[b2b_pkg::BCD_W-1:4]};
			next_beat.left = beat_s1.left - b2b_pkg::CNT_W'(1);
		end else begin
			next_beat.bcd  = {4'd0, beat_s1.bcd[b2b_pkg::BCD_W-1:4]};
		end
		if (beat_s1.left == b2b_pkg::CNT_W'(1)) begin
			next_beat.ovf = (quot != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			beat_s2 <= next_beat;
		end
	end

	assign out_valid = valid_s2;
	assign out_beat  = beat_s2;

endmodule

`default_nettype wire

/* rtl/binary_to_bcd_top.sv */
// ----------------------------------------------------------------------------
// binary_to_bcd_top
// Unsigned binary to packed BCD converter with a programmable digit count.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel bin_valid/bin_ready carries binary_value; output channel
//   bcd_valid/bcd_ready carries packed_bcd (digit zero in bits 3..0) and
//   overflow, set when the value needs more digits than are in use.
//   The digit count sits in the APB register at address 0 (4 bits, 0 acts
//   as 1, values above 8 act as 8, reset 8); write it only while idle.
//   Each digit takes two register stages (reciprocal multiply, then
//   remainder correction). One beat is accepted every cycle while the
//   output side is not stalled.
//   The last digit stage is the output register. When bcd_ready is low the
//   result holds and upstream stages keep filling empty slots; the input
//   stalls only when every stage is full.
//   Reset clears all valid bits and loads the digit count with 8.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_bcd_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [b2b_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [b2b_pkg::PDATA_W-1:0]   pwdata,
	output logic      [b2b_pkg::PDATA_W-1:0]   prdata,
	output logic                               pready,
	input  wire logic                          bin_valid,
	output logic                               bin_ready,
	input  wire logic [b2b_pkg::IN_W-1:0]      binary_value,
	output logic                               bcd_valid,
	input  wire logic                          bcd_ready,
	output logic      [b2b_pkg::OUT_W-1:0]     packed_bcd,
	output logic                               overflow
);

	localparam int N = b2b_pkg::MAX_DIGITS;

	logic [b2b_pkg::CFG_W-1:0] digits_q;
	logic [b2b_pkg::CNT_W-1:0] eff_digits;
	logic                      cfg_write;
	logic                      valid_chain [N+1];
	logic                      ready_chain [N+1];
	b2b_pkg::b2b_beat_t        beat_chain  [N+1];

	// APB register: written in the access phase
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready
		&& (paddr[2] == b2b_pkg::REG_DIGITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digits_q <= b2b_pkg::DIGITS_RESET;
		end else if (cfg_write) begin
			digits_q <= pwdata[b2b_pkg::CFG_W-1:0];
		end
	end

	assign prdata = (paddr[2] == b2b_pkg::REG_DIGITS)
		? b2b_pkg::PDATA_W'(digits_q) : '0;

	// Clamp the digit count into the supported range
	always_comb begin
		if (digits_q == '0) begin
			eff_digits = b2b_pkg::CNT_W'(1);
		end else if (digits_q > b2b_pkg::CFG_W'(N)) begin
			eff_digits = b2b_pkg::CNT_W'(N);
		end else begin
			eff_digits = b2b_pkg::CNT_W'(digits_q);
		end
	end

	// Head of the digit chain
	assign valid_chain[0]      = bin_valid;
	assign bin_ready           = ready_chain[0];
	assign beat_chain[0].value = b2b_pkg::VALUE_WIDTH'(binary_value);
	assign beat_chain[0].bcd   = '0;
	assign beat_chain[0].left  = eff_digits;
	assign beat_chain[0].ovf   = 1'b0;

	// One digit per instance, least significant first
	for (genvar k = 0; k < N; k++) begin : g_digit
		b2b_digit u_digit (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_chain[k]),
			.in_ready  (ready_chain[k]),
			.in_beat   (beat_chain[k]),
			.out_valid (valid_chain[k+1]),
			.out_ready (ready_chain[k+1]),
			.out_beat  (beat_chain[k+1])
		);
	end

	// Last stage register drives the output beat
	assign bcd_valid      = valid_chain[N];
	assign ready_chain[N] = bcd_ready;
	assign packed_bcd     = b2b_pkg::OUT_W'(beat_chain[N].bcd);
	assign overflow       = beat_chain[N].ovf;

endmodule

`default_nettype wire

/* rtl/b2b_checker.sv */
// ----------------------------------------------------------------------------
// b2b_checker
// Port-level checks for the binary-to-BCD converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module b2b_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      bcd_valid,
	input wire logic                      bcd_ready,
	input wire logic [b2b_pkg::OUT_W-1:0] packed_bcd,
	input wire logic                      overflow
);

	localparam int NIB = b2b_pkg::OUT_W / 4;

	logic nibbles_ok;

	// Every nibble of a result must be a decimal digit
	always_comb begin
		nibbles_ok = 1'b1;
		for (int i = 0; i < NIB; i++) begin
			if (packed_bcd[4*i +: 4] > 4'd9) begin
				nibbles_ok = 1'b0;
			end
		end
	end

	// Hold a stalled result beat
	assert property (@(posedge clk) disable iff (!arst_n)
		bcd_valid && !bcd_ready |=> bcd_valid && $stable(packed_bcd) && $stable(overflow))
	else $error("stalled result beat changed or dropped");

	// Results carry only decimal digits
	assert property (@(posedge clk) disable iff (!arst_n)
		bcd_valid |-> nibbles_ok)
	else $error("result holds a nibble above nine");

	// No result beat while reset is applied
	assert property (@(posedge clk) !arst_n |-> !bcd_valid)
	else $error("result valid during reset");

endmodule

bind binary_to_bcd_top b2b_checker u_b2b_checker (.*);

`default_nettype wire
